>>> rtl/core/slcf_pkg.sv
// Shared types, constants and the CRC byte step for the sync/length/CRC-32 frame parser.
package slcf_pkg;

    // Sync pattern and CRC polynomial (reflected CRC-32)
    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W    = 8;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED = 8'd1;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd512;
    localparam logic [31:0] CRC_SEED_RESET = 32'd1;

    // Position in the frame
    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_IDENT0  = 4'd2,
        PH_IDENT1  = 4'd3,
        PH_LEN0    = 4'd4,
        PH_LEN1    = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_TRL0    = 4'd7,
        PH_TRL1    = 4'd8,
        PH_TRL2    = 4'd9,
        PH_TRL3    = 4'd10
    } t_phase;

    // One result word
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        frame_end;
        logic        crc_good;
        logic [15:0] frame_ident;
        logic [15:0] frame_len;
        logic        length_error;
    } t_result;

    // One byte of reflected CRC-32: eight shift/xor steps on the low byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = {24'd0, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c ^ (crc >> 8);
    endfunction

endpackage

>>> rtl/core/slcf_fsm.sv
// Frame state machine: phase, header, counters, running CRC and the result of each byte.
module slcf_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [7:0]       i_rx_byte,
    input  logic [15:0]      i_max_len,
    input  logic [31:0]      i_crc_seed,
    output slcf_pkg::t_result o_result
);
    import slcf_pkg::*;

    t_phase      r_phase,   n_phase;
    logic [15:0] r_ident,   n_ident;
    logic [15:0] r_length,  n_length;
    logic [15:0] r_count,   n_count;
    logic [31:0] r_crc,     n_crc;
    logic [31:0] r_trailer, n_trailer;

    logic [31:0] crc_step;
    logic [15:0] count_inc;
    logic [15:0] len_full;
    logic [31:0] trailer_full;

    // CRC step over the incoming byte; base is the seed on the first sync byte
    assign crc_step     = crc_byte((r_phase == PH_SYNC1) ? i_crc_seed : r_crc, i_rx_byte);
    assign count_inc    = r_count + 16'd1;
    assign len_full     = {i_rx_byte, r_length[7:0]};
    assign trailer_full = {i_rx_byte, r_trailer[23:0]};

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SYNC1;
            r_ident   <= '0;
            r_length  <= '0;
            r_count   <= '0;
            r_crc     <= CRC_SEED_RESET;
            r_trailer <= '0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_ident   <= n_ident;
            r_length  <= n_length;
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_trailer <= n_trailer;
        end
    end

    // Next state and result for the byte at the input
    always_comb begin
        n_phase   = r_phase;
        n_ident   = r_ident;
        n_length  = r_length;
        n_count   = r_count;
        n_crc     = r_crc;
        n_trailer = r_trailer;
        o_result  = '0;
        unique case (r_phase)
            PH_SYNC1: begin
                if (i_rx_byte == SYNC_FIRST) begin
                    n_crc   = crc_step;
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (i_rx_byte == SYNC_SECOND) begin
                    n_crc   = crc_step;
                    n_phase = PH_IDENT0;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_IDENT0: begin
                n_ident = {8'd0, i_rx_byte};
                n_crc   = crc_step;
                n_phase = PH_IDENT1;
            end
            PH_IDENT1: begin
                n_ident = {i_rx_byte, r_ident[7:0]};
                n_crc   = crc_step;
                n_phase = PH_LEN0;
            end
            PH_LEN0: begin
                n_length = {8'd0, i_rx_byte};
                n_crc    = crc_step;
                n_phase  = PH_LEN1;
            end
            PH_LEN1: begin
                n_length = len_full;
                n_crc    = crc_step;
                if (len_full > i_max_len) begin
                    // oversize: report and drop the frame
                    o_result.frame_ident  = r_ident;
                    o_result.frame_len    = len_full;
                    o_result.length_error = 1'b1;
                    n_phase               = PH_SYNC1;
                end else begin
                    n_count = '0;
                    n_phase = (len_full == 16'd0) ? PH_TRL0 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                o_result.payload_valid = 1'b1;
                o_result.payload_byte  = i_rx_byte;
                o_result.payload_index = r_count;
                n_crc   = crc_step;
                n_count = count_inc;
                if (count_inc >= r_length) begin
                    n_phase = PH_TRL0;
                end
            end
            PH_TRL0: begin
                n_trailer = {24'd0, i_rx_byte};
                n_phase   = PH_TRL1;
            end
            PH_TRL1: begin
                n_trailer = {16'd0, i_rx_byte, r_trailer[7:0]};
                n_phase   = PH_TRL2;
            end
            PH_TRL2: begin
                n_trailer = {8'd0, i_rx_byte, r_trailer[15:0]};
                n_phase   = PH_TRL3;
            end
            PH_TRL3: begin
                n_trailer            = trailer_full;
                o_result.frame_end   = 1'b1;
                o_result.crc_good    = (trailer_full == r_crc);
                o_result.frame_ident = r_ident;
                o_result.frame_len   = r_length;
                n_phase              = PH_SYNC1;
            end
            default: begin
                n_phase = PH_SYNC1;
            end
        endcase
    end

endmodule

>>> rtl/core/sync_length_crc32_frame_parser.sv
// Top level of the sync/length/CRC-32 frame parser: config registers, handshake, result register.
//
// Takes one received byte per word and returns exactly one result word per byte. A byte is
// accepted every cycle while the result register is empty or being taken: the frame state
// machine and a byte-wide CRC-32 step sit between the input port and a single result
// register, so each result is registered in the cycle after its byte, one byte per clock. Input stall is
// raised only while a result waits and the output side stalls. Frames start at 0xAA 0x55,
// carry a little-endian identifier and length, the payload, and a little-endian CRC trailer
// checked against a reflected CRC-32 seeded from crc_seed with no final inversion.
// Configuration writes are always ready and must be made while the parser is idle.
module sync_length_crc32_frame_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // byte input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_rx_byte,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_payload_valid,
    output logic [7:0]                       o_payload_byte,
    output logic [15:0]                      o_payload_index,
    output logic                             o_frame_end,
    output logic                             o_crc_good,
    output logic [15:0]                      o_frame_ident,
    output logic [15:0]                      o_frame_len,
    output logic                             o_length_error,
    // configuration write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [slcf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);
    import slcf_pkg::*;

    logic [15:0] r_max_len;
    logic [31:0] r_crc_seed;
    logic        r_out_valid;
    t_result     r_result;
    t_result     fsm_result;
    logic        in_accept;
    logic        out_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = r_out_valid && !i_out_stall;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= MAX_LEN_RESET;
            r_crc_seed <= CRC_SEED_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_MAX_LEN) begin
                r_max_len <= i_cfg_data[15:0];
            end else if (i_cfg_index == REG_CRC_SEED) begin
                r_crc_seed <= i_cfg_data;
            end
        end
    end

    slcf_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (in_accept),
        .i_rx_byte  (i_rx_byte),
        .i_max_len  (r_max_len),
        .i_crc_seed (r_crc_seed),
        .o_result   (fsm_result)
    );

    // Result register: loads on every accepted byte, empties when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= fsm_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_valid = r_result.payload_valid;
    assign o_payload_byte  = r_result.payload_byte;
    assign o_payload_index = r_result.payload_index;
    assign o_frame_end     = r_result.frame_end;
    assign o_crc_good      = r_result.crc_good;
    assign o_frame_ident   = r_result.frame_ident;
    assign o_frame_len     = r_result.frame_len;
    assign o_length_error  = r_result.length_error;

    // Every accepted byte leaves a result waiting in the next cycle
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted byte produced no result");

    // A waiting, stalled result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !in_accept)
        else $error("result register overwritten while stalled");

    // Payload, frame end and length error are mutually exclusive
    a_kinds_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $countones({o_payload_valid, o_frame_end, o_length_error}) <= 1)
        else $error("result carries more than one kind");

    // CRC verdict only comes with a frame end
    a_good_with_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_crc_good) |-> o_frame_end)
        else $error("crc_good without frame_end");

endmodule

>>> verif/sync_length_crc32_frame_parser_tb.sv
// Self-checking testbench for the sync/length/CRC-32 frame parser.
module sync_length_crc32_frame_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slcf_pkg::*;

    // Register indexes that map to nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = 8'hFF;

    // Directed rows: a literal byte or one byte of the running CRC as trailer
    typedef enum logic {ROW_DATA, ROW_TRAILER} t_row_kind;
    typedef struct {
        t_row_kind  kind;
        logic [7:0] value;
        bit         typed;
        t_result    word;
    } t_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [7:0]           i_rx_byte   = 8'h00;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data  = 32'd0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_payload_valid;
    logic [7:0]           o_payload_byte;
    logic [15:0]          o_payload_index;
    logic                 o_frame_end;
    logic                 o_crc_good;
    logic [15:0]          o_frame_ident;
    logic [15:0]          o_frame_len;
    logic                 o_length_error;
    logic                 o_cfg_ready;

    // Parser model: configuration copy and frame state
    logic [15:0] cfg_max_len;
    logic [31:0] cfg_seed;
    t_phase      pr_phase;
    logic [15:0] pr_ident;
    logic [15:0] pr_len;
    logic [15:0] pr_count;
    logic [31:0] pr_crc;
    logic [31:0] pr_trailer;

    t_result result_words_due[$];
    t_row    directed_rows[$];
    int      mismatch_count = 0;
    int      bytes_sent     = 0;
    bit      gaps_on        = 1'b1;
    t_result due_word;
    t_result got_word;

    sync_length_crc32_frame_parser DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_frame_end     (o_frame_end),
        .o_crc_good      (o_crc_good),
        .o_frame_ident   (o_frame_ident),
        .o_frame_len     (o_frame_len),
        .o_length_error  (o_length_error),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Reflected CRC-32, one bit per shift over the whole register
    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

    // Advance the frame state by one byte and return the word it produces
    function automatic t_result parse_byte(input logic [7:0] b);
        t_result w;
        w = '0;
        case (pr_phase)
            PH_SYNC1: begin
                if (b == SYNC_FIRST) begin
                    pr_crc   = crc32_step(cfg_seed, b);
                    pr_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (b == SYNC_SECOND) begin
                    pr_crc   = crc32_step(pr_crc, b);
                    pr_phase = PH_IDENT0;
                end else begin
                    pr_phase = PH_SYNC1;
                end
            end
            PH_IDENT0: begin
                pr_ident = {8'd0, b};
                pr_crc   = crc32_step(pr_crc, b);
                pr_phase = PH_IDENT1;
            end
            PH_IDENT1: begin
                pr_ident[15:8] = b;
                pr_crc         = crc32_step(pr_crc, b);
                pr_phase       = PH_LEN0;
            end
            PH_LEN0: begin
                pr_len   = {8'd0, b};
                pr_crc   = crc32_step(pr_crc, b);
                pr_phase = PH_LEN1;
            end
            PH_LEN1: begin
                pr_len[15:8] = b;
                pr_crc       = crc32_step(pr_crc, b);
                if (pr_len > cfg_max_len) begin
                    w.frame_ident  = pr_ident;
                    w.frame_len    = pr_len;
                    w.length_error = 1'b1;
                    pr_phase       = PH_SYNC1;
                end else begin
                    pr_count = 16'd0;
                    pr_phase = (pr_len == 16'd0) ? PH_TRL0 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                w.payload_valid = 1'b1;
                w.payload_byte  = b;
                w.payload_index = pr_count;
                pr_crc          = crc32_step(pr_crc, b);
                pr_count        = pr_count + 16'd1;
                if (pr_count >= pr_len) pr_phase = PH_TRL0;
            end
            PH_TRL0: begin
                pr_trailer = {24'd0, b};
                pr_phase   = PH_TRL1;
            end
            PH_TRL1: begin
                pr_trailer[15:8] = b;
                pr_phase         = PH_TRL2;
            end
            PH_TRL2: begin
                pr_trailer[23:16] = b;
                pr_phase          = PH_TRL3;
            end
            PH_TRL3: begin
                pr_trailer[31:24] = b;
                w.frame_end       = 1'b1;
                w.crc_good        = (pr_trailer == pr_crc);
                w.frame_ident     = pr_ident;
                w.frame_len       = pr_len;
                pr_phase          = PH_SYNC1;
            end
            default: begin
                pr_phase = PH_SYNC1;
            end
        endcase
        return w;
    endfunction

    // Trailer byte that matches the running CRC at the current trailer position
    function automatic logic [7:0] trailer_byte();
        return pr_crc[8 * (pr_phase - PH_TRL0) +: 8];
    endfunction

    // Put one byte on the input port, hold it until taken, then predict its word
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input t_result word = '0);
        int      gap;
        int      r;
        t_result w;
        r   = $urandom_range(0, 99);
        gap = !gaps_on ? 0 :
              (r < 60) ? 0 :
              (r < 88) ? $urandom_range(1, 3) :
              (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        w = parse_byte(b);
        result_words_due.push_back(typed ? word : w);
        bytes_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_MAX_LEN) cfg_max_len = data[15:0];
        else if (idx == REG_CRC_SEED) cfg_seed = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_row(input t_row_kind kind, input logic [7:0] value, input bit typed,
                           input t_result word);
        t_row r;
        r.kind  = kind;
        r.value = value;
        r.typed = typed;
        r.word  = word;
        directed_rows.push_back(r);
    endtask

    // Finish any open frame, drop valid and let every outstanding word drain
    task automatic settle();
        int n;
        while (pr_phase != PH_SYNC1) send_byte(8'h00);
        i_in_valid <= 1'b0;
        n = 0;
        while (result_words_due.size() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        if (result_words_due.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, result_words_due.size());
            mismatch_count++;
            result_words_due.delete();
        end
        repeat (3) @(posedge i_clk);
    endtask

    // One frame: optionally over the limit, cut inside the header, or with a bad trailer
    task automatic send_frame(input bit corrupt, input bit too_long, input int cut_at,
                              input int fixed_len);
        logic [15:0] ident;
        logic [15:0] len;
        logic [7:0]  hdr[6];
        logic [7:0]  b;
        int          cap;
        int          hi;
        int          r;
        int          k;
        int          bad_k;
        int          n_hdr;
        r     = $urandom_range(0, 9);
        ident = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom());
        cap   = (cfg_max_len < 16'd12) ? int'(cfg_max_len) : 12;
        if (fixed_len >= 0) begin
            len = 16'(fixed_len);
        end else if (too_long) begin
            hi  = int'(cfg_max_len) + 64;
            if (hi > 65535) hi = 65535;
            len = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                  16'($urandom_range(int'(cfg_max_len) + 1, hi));
        end else begin
            r = $urandom_range(0, 9);
            if (r == 0) len = 16'd0;
            else if (r == 1 && cfg_max_len <= 16'd300) len = cfg_max_len;
            else len = 16'($urandom_range(0, cap));
        end
        hdr   = '{SYNC_FIRST, SYNC_SECOND, ident[7:0], ident[15:8], len[7:0], len[15:8]};
        n_hdr = (cut_at > 0) ? cut_at : 6;
        for (k = 0; k < n_hdr; k++) send_byte(hdr[k]);
        if (cut_at == 0) begin
            while (pr_phase == PH_PAYLOAD) send_byte(8'($urandom()));
            bad_k = $urandom_range(0, 3);
            k     = 0;
            while (pr_phase >= PH_TRL0 && pr_phase <= PH_TRL3) begin
                b = trailer_byte();
                if (corrupt && k == bad_k) b = b ^ (8'd1 << $urandom_range(0, 7));
                send_byte(b);
                k++;
            end
        end
    endtask

    // Stray bytes, rich in sync values; no sync start when long frames are allowed
    task automatic send_noise();
        int         n;
        int         r;
        logic [7:0] b;
        n = $urandom_range(1, 6);
        repeat (n) begin
            r = $urandom_range(0, 7);
            b = (r == 0) ? SYNC_FIRST : (r == 1) ? SYNC_SECOND : 8'($urandom());
            if (cfg_max_len > 16'd1024 && b == SYNC_FIRST) b = 8'h00;
            send_byte(b);
        end
    endtask

    // Mostly well-formed frames with random content, the rest errors and noise
    task automatic run_traffic(input int n);
        int stop_at;
        int r;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            r       = $urandom_range(0, 99);
            if (r < 72) send_frame($urandom_range(0, 6) == 0, 1'b0, 0, -1);
            else if (r < 82 && cfg_max_len != 16'hFFFF) send_frame(1'b0, 1'b1, 0, -1);
            else if (r < 90 && cfg_max_len <= 16'd1024)
                send_frame(1'b0, 1'b0, $urandom_range(1, 5), -1);
            else send_noise();
        end
        gaps_on = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Output stall: short bursts, rare long ones, and long open stretches
    initial begin : out_stall_gen
        int run;
        int hold;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 8);
            i_out_stall <= 1'b0;
            repeat (run) @(posedge i_clk);
            hold = ($urandom_range(0, 29) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            i_out_stall <= 1'b1;
            repeat (hold) @(posedge i_clk);
        end
    end

    // Compare every taken result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_words_due.size() == 0) begin
                $display("%0t: result word with nothing expected", $time);
                mismatch_count++;
            end else begin
                due_word = result_words_due.pop_front();
                got_word = '{o_payload_valid, o_payload_byte, o_payload_index, o_frame_end,
                             o_crc_good, o_frame_ident, o_frame_len, o_length_error};
                check_field("payload_valid", 32'(due_word.payload_valid),
                            32'(got_word.payload_valid));
                check_field("payload_byte", 32'(due_word.payload_byte),
                            32'(got_word.payload_byte));
                check_field("payload_index", 32'(due_word.payload_index),
                            32'(got_word.payload_index));
                check_field("frame_end", 32'(due_word.frame_end), 32'(got_word.frame_end));
                check_field("crc_good", 32'(due_word.crc_good), 32'(got_word.crc_good));
                check_field("frame_ident", 32'(due_word.frame_ident),
                            32'(got_word.frame_ident));
                check_field("frame_len", 32'(due_word.frame_len), 32'(got_word.frame_len));
                check_field("length_error", 32'(due_word.length_error),
                            32'(got_word.length_error));
            end
        end
    end

    initial begin : stimulus
        t_result zero_word;
        t_result len_err_word;
        t_row    row;
        int      i;

        // Model state after reset
        cfg_max_len = MAX_LEN_RESET;
        cfg_seed    = CRC_SEED_RESET;
        pr_phase    = PH_SYNC1;
        pr_ident    = 16'd0;
        pr_len      = 16'd0;
        pr_count    = 16'd0;
        pr_crc      = CRC_SEED_RESET;
        pr_trailer  = 32'd0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        zero_word                 = '0;
        len_err_word              = '0;
        len_err_word.frame_ident  = 16'hFFFF;
        len_err_word.frame_len    = 16'h0201;
        len_err_word.length_error = 1'b1;

        // Idle byte, then a sync byte followed by a wrong second byte, twice
        add_row(ROW_DATA, 8'h00, 1'b1, zero_word);
        add_row(ROW_DATA, SYNC_FIRST, 1'b1, zero_word);
        add_row(ROW_DATA, 8'h00, 1'b1, zero_word);
        add_row(ROW_DATA, SYNC_FIRST, 1'b1, zero_word);
        add_row(ROW_DATA, SYNC_FIRST, 1'b1, zero_word);
        add_row(ROW_DATA, SYNC_SECOND, 1'b1, zero_word);
        // Length one above the reset limit, all-ones identifier
        add_row(ROW_DATA, SYNC_FIRST, 1'b1, zero_word);
        add_row(ROW_DATA, SYNC_SECOND, 1'b1, zero_word);
        add_row(ROW_DATA, 8'hFF, 1'b1, zero_word);
        add_row(ROW_DATA, 8'hFF, 1'b1, zero_word);
        add_row(ROW_DATA, 8'h01, 1'b1, zero_word);
        add_row(ROW_DATA, 8'h02, 1'b1, len_err_word);
        // Zero-length frame straight into a matching trailer
        add_row(ROW_DATA, SYNC_FIRST, 1'b1, zero_word);
        add_row(ROW_DATA, SYNC_SECOND, 1'b1, zero_word);
        add_row(ROW_DATA, 8'h00, 1'b1, zero_word);
        add_row(ROW_DATA, 8'h00, 1'b1, zero_word);
        add_row(ROW_DATA, 8'h00, 1'b1, zero_word);
        add_row(ROW_DATA, 8'h00, 1'b1, zero_word);
        repeat (4) add_row(ROW_TRAILER, 8'h00, 1'b0, zero_word);

        for (i = 0; i < directed_rows.size(); i++) begin
            row = directed_rows[i];
            send_byte((row.kind == ROW_TRAILER) ? trailer_byte() : row.value, row.typed,
                      row.word);
        end
        run_traffic(250);

        // Tightest limit and zero seed: every nonzero length is dropped
        settle();
        cfg_write(REG_MAX_LEN, 32'd0);
        cfg_write(REG_CRC_SEED, 32'd0);
        run_traffic(250);

        // Widest limit and all-ones seed, one long frame back to back
        settle();
        cfg_write(REG_MAX_LEN, 32'h0000_FFFF);
        cfg_write(REG_CRC_SEED, 32'hFFFF_FFFF);
        gaps_on = 1'b0;
        send_frame(1'b0, 1'b0, 0, 200);
        gaps_on = 1'b1;
        run_traffic(50);

        // Unmapped indexes change nothing
        settle();
        cfg_write(REG_SPARE, $urandom());
        cfg_write(REG_SPARE_TOP, $urandom());
        cfg_write(REG_MAX_LEN, 32'd12);
        cfg_write(REG_CRC_SEED, $urandom());
        run_traffic(250);

        settle();
        cfg_write(REG_MAX_LEN, $urandom_range(1, 300));
        cfg_write(REG_CRC_SEED, $urandom());
        run_traffic(300);

        settle();
        cfg_write(REG_MAX_LEN, $urandom());
        cfg_write(REG_CRC_SEED, $urandom());
        run_traffic(250);

        settle();
        if (mismatch_count == 0) begin
            $display("sync_length_crc32_frame_parser regression: pass");
        end else begin
            $display("sync_length_crc32_frame_parser regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #200_000_000;
        $display("sync_length_crc32_frame_parser regression: fail");
        $finish;
    end

endmodule

>>> sync_length_crc32_frame_parser.f
rtl/core/slcf_pkg.sv
rtl/core/slcf_fsm.sv
rtl/core/sync_length_crc32_frame_parser.sv
verif/sync_length_crc32_frame_parser_tb.sv
